// ----- design/fft_with_peak_bin_unit_assert.svh -----
// assertion macros for the fft peak unit
`ifndef FFT_WITH_PEAK_BIN_UNIT_ASSERT_SVH
`define FFT_WITH_PEAK_BIN_UNIT_ASSERT_SVH

// same-cycle implication
`define FWPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fwpb_pkg.sv -----
`default_nettype none
package fwpb_pkg;

  localparam int MaxPointsLog2Def = 10;
  localparam int TwiddleBitsDef   = 18;
  localparam int SampleBits       = 16;
  localparam int PointIdxW        = 10;
  localparam int CfgDataW         = 10;
  localparam int CfgIdxW          = 2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FFT   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_SIZE_LOG2 = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERSE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_LAST = 2'd2;

  localparam logic [3:0]          SizeLog2Rst = 4'd10;
  localparam logic [PointIdxW-1:0] PeakLastRst = 10'd512;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [2:0] WR_SAMPLE = 3'd0;
  localparam logic [2:0] WR_RDA    = 3'd1;
  localparam logic [2:0] WR_RDB    = 3'd2;
  localparam logic [2:0] WR_DIFF   = 3'd3;
  localparam logic [2:0] WR_SUM    = 3'd4;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [PointIdxW-1:0]        point_index;
    logic signed [SampleBits-1:0] sample_real;
    logic signed [SampleBits-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic                 result_kind;
    logic signed [31:0]   bin_real;
    logic signed [31:0]   bin_imag;
    logic [PointIdxW-1:0] peak_bin;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [2:0] wr_sel;
    logic       tw_quad;
    logic       inverse;
    logic       mul_en;
    logic       sum_en;
    logic       mag_en;
    logic       cmp_en;
    logic       cmp_first;
    logic       out_load;
    logic       out_kind;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  localparam longint unsigned TwoPiQ40 = 64'hC90FDAA22168C234 >> 21;
  localparam longint unsigned OneQ30   = 64'd1 << 30;

  function automatic longint unsigned div_sin(input longint unsigned v, input int unsigned n);
    case (n)
      1: return v / 6;
      2: return v / 20;
      3: return v / 42;
      4: return v / 72;
      5: return v / 110;
      6: return v / 156;
      7: return v / 210;
      8: return v / 272;
      9: return v / 342;
      default: return v / 420;
    endcase
  endfunction

  function automatic longint unsigned div_cos(input longint unsigned v, input int unsigned n);
    case (n)
      1: return v / 2;
      2: return v / 12;
      3: return v / 30;
      4: return v / 56;
      5: return v / 90;
      6: return v / 132;
      7: return v / 182;
      8: return v / 240;
      9: return v / 306;
      default: return v / 380;
    endcase
  endfunction

  // quarter-wave twiddle magnitude, taylor series in q30 then rounded to q2.tf
  function automatic longint unsigned tw_calc(input int unsigned r, input int unsigned m,
                                              input int unsigned tf, input bit want_cos);
    longint unsigned x, x2, ts, tc, rr;
    longint ss, cs, v;
    x  = (TwoPiQ40 * longint'(r) + (64'd1 << (m + 9))) >> (m + 10);
    x2 = (x * x) >> 30;
    ts = x;
    tc = OneQ30;
    ss = longint'(x);
    cs = longint'(OneQ30);
    for (int unsigned n = 1; n <= 10; n++) begin
      ts = div_sin((ts * x2) >> 30, n);
      tc = div_cos((tc * x2) >> 30, n);
      if (n % 2 == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    v = want_cos ? cs : ss;
    if (v < 0) v = 0;
    rr = (longint'(v) + (64'd1 << (29 - tf))) >> (30 - tf);
    if (rr > (64'd1 << tf)) rr = 64'd1 << tf;
    return rr;
  endfunction

endpackage
`default_nettype wire

// ----- design/fft_with_peak_bin_unit.sv -----
// Complex-sample buffer with an in-place radix-2 FFT and peak-bin search. A write beat
// stores one sample and is taken every cycle while idle; a read beat registers the entry,
// then loads it into the output register once free. A transform of n = 2^size_log2 points
// does bit-reversal swaps, (n/2)*log2(n) butterflies (read, multiply, sum, write q, write p)
// and a read, square and compare per bin searched, then posts the result; the single write
// port of the 1024 x 64 sample memory (two read ports) splits each butterfly's writes.
// Buffer entries are not cleared at reset and hold garbage until written. A finished result
// sits in an output register, so a new beat is taken while the previous result waits.
`default_nettype none
module fft_with_peak_bin_unit #(
  parameter int MAX_POINTS_LOG2 = fwpb_pkg::MaxPointsLog2Def,
  parameter int TWIDDLE_BITS    = fwpb_pkg::TwiddleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  fwpb_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output fwpb_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fwpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fwpb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int RW = (MAX_POINTS_LOG2 > 2) ? MAX_POINTS_LOG2 - 2 : 1;

  fwpb_pkg::cmd_t              cmd;
  fwpb_pkg::status_t           status;
  logic [MAX_POINTS_LOG2-1:0]  rd_a, rd_b, wr_addr, bin;
  logic [RW-1:0]               tw_addr;

  fwpb_ctrl #(
    .MAX_POINTS_LOG2(MAX_POINTS_LOG2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (in_data_i.mode),
    .in_index_i  (in_data_i.point_index),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b),
    .wr_addr_o   (wr_addr),
    .tw_addr_o   (tw_addr),
    .bin_o       (bin)
  );

  fwpb_datapath #(
    .MAX_POINTS_LOG2(MAX_POINTS_LOG2),
    .TWIDDLE_BITS   (TWIDDLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .wr_addr_i   (wr_addr),
    .tw_addr_i   (tw_addr),
    .bin_i       (bin),
    .sample_i    (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- design/fwpb_ctrl.sv -----
`default_nettype none
module fwpb_ctrl #(
  parameter int MAX_POINTS_LOG2 = fwpb_pkg::MaxPointsLog2Def
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     in_mode_i,
  input  wire logic [fwpb_pkg::PointIdxW-1:0] in_index_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fwpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fwpb_pkg::CfgDataW-1:0]  cfg_data_i,
  output fwpb_pkg::cmd_t                      cmd_o,
  input  fwpb_pkg::status_t                   status_i,
  output logic [MAX_POINTS_LOG2-1:0]          rd_a_o,
  output logic [MAX_POINTS_LOG2-1:0]          rd_b_o,
  output logic [MAX_POINTS_LOG2-1:0]          wr_addr_o,
  output logic [((MAX_POINTS_LOG2 > 2) ? MAX_POINTS_LOG2 - 2 : 1)-1:0] tw_addr_o,
  output logic [MAX_POINTS_LOG2-1:0]          bin_o
);

  localparam int AW      = MAX_POINTS_LOG2;
  localparam int BW      = AW - 1;
  localparam int RW      = (AW > 2) ? AW - 2 : 1;
  localparam int Quarter = 1 << (AW - 2);
  localparam int LW      = (AW > 10) ? AW : 10;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD_OUT = 4'd1;
  localparam logic [3:0] ST_BR_CHK = 4'd2;
  localparam logic [3:0] ST_BR_W1  = 4'd3;
  localparam logic [3:0] ST_BR_W2  = 4'd4;
  localparam logic [3:0] ST_BF_RD  = 4'd5;
  localparam logic [3:0] ST_BF_MUL = 4'd6;
  localparam logic [3:0] ST_BF_SUM = 4'd7;
  localparam logic [3:0] ST_BF_WQ  = 4'd8;
  localparam logic [3:0] ST_BF_WP  = 4'd9;
  localparam logic [3:0] ST_PK_RD  = 4'd10;
  localparam logic [3:0] ST_PK_MUL = 4'd11;
  localparam logic [3:0] ST_PK_CMP = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  logic [3:0]                      state_q, state_d;
  logic [AW-1:0]                   i_q, i_d;
  logic [BW-1:0]                   b_q, b_d;
  logic [3:0]                      s_q, s_d;
  logic [3:0]                      size_q;
  logic                            inv_q;
  logic [fwpb_pkg::CfgDataW-1:0]   last_q;
  logic [3:0]                      lg_eff;
  logic [AW-1:0]                   n_last, limit, rev_full, j_idx, p_idx, q_idx, t_idx;
  logic [BW-1:0]                   b_last, mask, k_idx;
  logic                            accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= fwpb_pkg::SizeLog2Rst;
      inv_q  <= 1'b0;
      last_q <= fwpb_pkg::PeakLastRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fwpb_pkg::CFG_SIZE_LOG2: size_q <= cfg_data_i[3:0];
        fwpb_pkg::CFG_INVERSE:   inv_q  <= cfg_data_i[0];
        fwpb_pkg::CFG_PEAK_LAST: last_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_q == 4'd0) begin
      lg_eff = 4'd1;
    end else if (size_q > 4'(AW)) begin
      lg_eff = 4'(AW);
    end else begin
      lg_eff = size_q;
    end
    n_last = AW'((32'd1 << lg_eff) - 32'd1);
    b_last = BW'((32'd1 << (lg_eff - 4'd1)) - 32'd1);
    limit  = (LW'(last_q) > LW'(n_last)) ? n_last : AW'(last_q);
    for (int b = 0; b < AW; b++) begin
      rev_full[AW-1-b] = i_q[b];
    end
    j_idx  = rev_full >> (4'(AW) - lg_eff);
    mask   = BW'((32'd1 << (s_q - 4'd1)) - 32'd1);
    k_idx  = b_q & mask;
    p_idx  = (AW'(b_q & ~mask) << 1) | AW'(k_idx);
    q_idx  = p_idx | AW'(32'd1 << (s_q - 4'd1));
    t_idx  = AW'(k_idx) << (4'(AW) - s_q);
  end

  assign tw_addr_o = RW'(t_idx & AW'(Quarter - 1));

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    b_d       = b_q;
    s_d       = s_q;
    cmd_o     = '0;
    cmd_o.tw_quad = t_idx[AW-2];
    cmd_o.inverse = inv_q;
    rd_a_o    = '0;
    rd_b_o    = '0;
    wr_addr_o = '0;
    bin_o     = i_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            fwpb_pkg::MODE_WRITE: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = fwpb_pkg::WR_SAMPLE;
              wr_addr_o    = AW'(in_index_i);
            end
            fwpb_pkg::MODE_READ: begin
              cmd_o.rd_en = 1'b1;
              rd_a_o      = AW'(in_index_i);
              rd_b_o      = AW'(in_index_i);
              state_d     = ST_RD_OUT;
            end
            fwpb_pkg::MODE_FFT: begin
              i_d     = '0;
              state_d = ST_BR_CHK;
            end
            default: ;
          endcase
        end
      end
      ST_RD_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = fwpb_pkg::KIND_READ;
          state_d        = ST_IDLE;
        end
      end
      ST_BR_CHK, ST_BR_W2: begin
        if (state_q == ST_BR_CHK && j_idx > i_q) begin
          cmd_o.rd_en = 1'b1;
          rd_a_o      = i_q;
          rd_b_o      = j_idx;
          state_d     = ST_BR_W1;
        end else begin
          if (state_q == ST_BR_W2) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = fwpb_pkg::WR_RDA;
            wr_addr_o    = j_idx;
          end
          if (i_q == n_last) begin
            s_d     = 4'd1;
            b_d     = '0;
            state_d = ST_BF_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_BR_CHK;
          end
        end
      end
      ST_BR_W1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = fwpb_pkg::WR_RDB;
        wr_addr_o    = i_q;
        state_d      = ST_BR_W2;
      end
      ST_BF_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_a_o      = p_idx;
        rd_b_o      = q_idx;
        state_d     = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_BF_WQ;
      end
      ST_BF_WQ: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = fwpb_pkg::WR_DIFF;
        wr_addr_o    = q_idx;
        state_d      = ST_BF_WP;
      end
      ST_BF_WP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = fwpb_pkg::WR_SUM;
        wr_addr_o    = p_idx;
        if (b_q == b_last) begin
          if (s_q == lg_eff) begin
            i_d     = '0;
            state_d = ST_PK_RD;
          end else begin
            s_d     = s_q + 4'd1;
            b_d     = '0;
            state_d = ST_BF_RD;
          end
        end else begin
          b_d     = b_q + 1'b1;
          state_d = ST_BF_RD;
        end
      end
      ST_PK_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_a_o      = i_q;
        rd_b_o      = i_q;
        state_d     = ST_PK_MUL;
      end
      ST_PK_MUL: begin
        cmd_o.mag_en = 1'b1;
        state_d      = ST_PK_CMP;
      end
      ST_PK_CMP: begin
        cmd_o.cmp_en    = 1'b1;
        cmd_o.cmp_first = (i_q == '0);
        if (i_q == limit) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_PK_RD;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = fwpb_pkg::KIND_PEAK;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      b_q     <= '0;
      s_q     <= 4'd1;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      b_q     <= b_d;
      s_q     <= s_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/fwpb_datapath.sv -----
`default_nettype none
module fwpb_datapath #(
  parameter int MAX_POINTS_LOG2 = fwpb_pkg::MaxPointsLog2Def,
  parameter int TWIDDLE_BITS    = fwpb_pkg::TwiddleBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  fwpb_pkg::cmd_t             cmd_i,
  output fwpb_pkg::status_t          status_o,
  input  wire logic [MAX_POINTS_LOG2-1:0] rd_a_i,
  input  wire logic [MAX_POINTS_LOG2-1:0] rd_b_i,
  input  wire logic [MAX_POINTS_LOG2-1:0] wr_addr_i,
  input  wire logic [((MAX_POINTS_LOG2 > 2) ? MAX_POINTS_LOG2 - 2 : 1)-1:0] tw_addr_i,
  input  wire logic [MAX_POINTS_LOG2-1:0] bin_i,
  input  fwpb_pkg::in_item_t         sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output fwpb_pkg::out_item_t        out_data_o
);

  localparam int AW      = MAX_POINTS_LOG2;
  localparam int Depth   = 1 << AW;
  localparam int Quarter = 1 << (AW - 2);
  localparam int TW      = TWIDDLE_BITS;
  localparam int Frac    = TW - 2;
  localparam int PW      = TW + 32;
  localparam int VW      = TW + 35;
  localparam logic signed [VW-1:0] OneV = VW'(1);
  localparam logic signed [VW-1:0] Rnd  = OneV <<< (Frac - 1);
  localparam logic signed [VW-1:0] SMax = (OneV <<< 31) - OneV;
  localparam logic signed [VW-1:0] SMin = -(OneV <<< 31);

  logic [63:0]          mem [Depth];
  logic [63:0]          rda_q, rdb_q, wr_data;
  logic [TW-1:0]        cos_rom [Quarter];
  logic [TW-1:0]        sin_rom [Quarter];
  logic [TW-1:0]        cos_q, sin_q;
  logic signed [TW-1:0] wr_w, wi_w;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [VW-1:0] vr, vi, vr_rnd, vi_rnd;
  logic signed [31:0]   tr_q, ti_q, ar, ai, xr, xi;
  logic signed [63:0]   mag_r_q, mag_i_q;
  logic [63:0]          mag, best_mag_q;
  logic [AW-1:0]        best_q;
  logic                 out_valid_q;
  fwpb_pkg::out_item_t  out_q;

  for (genvar g = 0; g < Quarter; g++) begin : g_rom
    localparam logic [TW-1:0] CosV = TW'(fwpb_pkg::tw_calc(g, AW, Frac, 1'b1));
    localparam logic [TW-1:0] SinV = TW'(fwpb_pkg::tw_calc(g, AW, Frac, 1'b0));
    assign cos_rom[g] = CosV;
    assign sin_rom[g] = SinV;
  end

  function automatic logic signed [31:0] sat_v(input logic signed [VW-1:0] v);
    if (v > SMax) return 32'sh7fffffff;
    if (v < SMin) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [32:0] s);
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    return s[31:0];
  endfunction

  assign ar = rda_q[63:32];
  assign ai = rda_q[31:0];
  assign xr = rdb_q[63:32];
  assign xi = rdb_q[31:0];

  always_comb begin
    wr_w = cmd_i.tw_quad ? -$signed(sin_q) : $signed(cos_q);
    wi_w = cmd_i.tw_quad ? $signed(cos_q) : $signed(sin_q);
    if (cmd_i.inverse) wi_w = -wi_w;
    vr     = VW'(p_rr_q) - VW'(p_ii_q);
    vi     = VW'(p_ri_q) + VW'(p_ir_q);
    vr_rnd = (vr + Rnd) >>> Frac;
    vi_rnd = (vi + Rnd) >>> Frac;
    mag    = $unsigned(mag_r_q) + $unsigned(mag_i_q);
    case (cmd_i.wr_sel)
      fwpb_pkg::WR_SAMPLE: wr_data = {32'(sample_i.sample_real), 32'(sample_i.sample_imag)};
      fwpb_pkg::WR_RDA:    wr_data = rda_q;
      fwpb_pkg::WR_RDB:    wr_data = rdb_q;
      fwpb_pkg::WR_DIFF:   wr_data = {sat_add(33'(ar) - 33'(tr_q)), sat_add(33'(ai) - 33'(ti_q))};
      fwpb_pkg::WR_SUM:    wr_data = {sat_add(33'(ar) + 33'(tr_q)), sat_add(33'(ai) + 33'(ti_q))};
      default:             wr_data = rda_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr_i] <= wr_data;
    if (cmd_i.rd_en) begin
      rda_q <= mem[rd_a_i];
      rdb_q <= mem[rd_b_i];
      cos_q <= cos_rom[tw_addr_i];
      sin_q <= sin_rom[tw_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= wr_w * xr;
      p_ii_q <= wi_w * xi;
      p_ri_q <= wr_w * xi;
      p_ir_q <= wi_w * xr;
    end
    if (cmd_i.sum_en) begin
      tr_q <= sat_v(vr_rnd);
      ti_q <= sat_v(vi_rnd);
    end
    if (cmd_i.mag_en) begin
      mag_r_q <= 64'(ar) * 64'(ar);
      mag_i_q <= 64'(ai) * 64'(ai);
    end
    if (cmd_i.cmp_en && (cmd_i.cmp_first || mag > best_mag_q)) begin
      best_mag_q <= mag;
      best_q     <= bin_i;
    end
    if (cmd_i.out_load) begin
      out_q.result_kind <= cmd_i.out_kind;
      if (cmd_i.out_kind == fwpb_pkg::KIND_READ) begin
        out_q.bin_real <= ar;
        out_q.bin_imag <= ai;
        out_q.peak_bin <= '0;
      end else begin
        out_q.bin_real <= '0;
        out_q.bin_imag <= '0;
        out_q.peak_bin <= fwpb_pkg::PointIdxW'(best_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
`default_nettype wire

// ----- design/fwpb_checker.sv -----
`default_nettype none
`include "fft_with_peak_bin_unit_assert.svh"
module fwpb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input fwpb_pkg::in_item_t       in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input fwpb_pkg::out_item_t      out_data_o
);

  `FWPB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")
  `FWPB_ASSERT_NOW(a_read_no_peak, out_valid_o && out_data_o.result_kind, out_data_o.peak_bin == '0, "read beat carries peak bin")
  `FWPB_ASSERT_NOW(a_peak_no_bin, out_valid_o && !out_data_o.result_kind, out_data_o.bin_real == '0 && out_data_o.bin_imag == '0, "peak beat carries bin data")
  `FWPB_ASSERT_NEXT(a_write_silent, in_valid_i && in_ready_o && !out_valid_o && in_data_i.mode == fwpb_pkg::MODE_WRITE, !out_valid_o, "write beat produced a result")

endmodule

bind fft_with_peak_bin_unit fwpb_checker u_fwpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [fwpb_pkg::CfgIdxW-1:0] CfgNoReg = 2'd3;
  localparam int Depth = 1024;
  localparam int Span = 256;
  localparam int TwFrac = 16;
  localparam longint unsigned TwoPiQ40 = 64'hC90FDAA22168C234 >> 21;
  localparam int StallLimit = 200000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [fwpb_pkg::CfgIdxW-1:0] cfg_index;
  logic [fwpb_pkg::CfgDataW-1:0] cfg_data;
  fwpb_pkg::in_item_t in_data;
  fwpb_pkg::out_item_t out_data;

  fft_with_peak_bin_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  int bins_re [Depth];
  int bins_im [Depth];
  longint tw_cos [Depth];
  longint tw_sin [Depth];
  logic [3:0] size_lg;
  logic inv;
  logic [9:0] peak_last;

  fwpb_pkg::out_item_t expected_q[$];
  int errors, n_writes, n_reads, n_ffts, n_results;
  bit calm;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint rnd_shift(longint v);
    return (v + (64'sd1 <<< (TwFrac - 1))) >>> TwFrac;
  endfunction

  function automatic longint q30_to_q16(longint v);
    longint unsigned r;
    if (v < 0) v = 0;
    r = (longint'(v) + (64'd1 << 13)) >> 14;
    if (r > (64'd1 << TwFrac)) r = 64'd1 << TwFrac;
    return longint'(r);
  endfunction

  task automatic build_twiddles();
    longint unsigned x, x2, ts, tc;
    longint ss, cs, c, s;
    int q, r;
    for (int t = 0; t < Depth; t++) begin
      q = t / 256;
      r = t % 256;
      x = (TwoPiQ40 * longint'(r) + (64'd1 << 19)) >> 20;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cs = longint'(64'd1 << 30);
      for (int n = 1; n <= 10; n++) begin
        ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          ss -= longint'(ts);
          cs -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cs += longint'(tc);
        end
      end
      c = q30_to_q16(cs);
      s = q30_to_q16(ss);
      case (q)
        0: begin tw_cos[t] = c; tw_sin[t] = s; end
        1: begin tw_cos[t] = -s; tw_sin[t] = c; end
        2: begin tw_cos[t] = -c; tw_sin[t] = -s; end
        default: begin tw_cos[t] = s; tw_sin[t] = -c; end
      endcase
    end
  endtask

  function automatic logic [9:0] fft_peak();
    int lg, n, j, lim, half, len, step, p, q, tmp;
    longint wr, wi, xr, xi, tr, ti, ar, ai;
    longint unsigned mag, best_mag;
    logic [9:0] best;
    lg = (size_lg < 1) ? 1 : ((size_lg > 10) ? 10 : size_lg);
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < lg; b++) j |= ((i >> b) & 1) << (lg - 1 - b);
      if (j > i) begin
        tmp = bins_re[i]; bins_re[i] = bins_re[j]; bins_re[j] = tmp;
        tmp = bins_im[i]; bins_im[i] = bins_im[j]; bins_im[j] = tmp;
      end
    end
    for (int s = 1; s <= lg; s++) begin
      len = 1 << s;
      half = len >> 1;
      step = Depth >> s;
      for (int k = 0; k < half; k++) begin
        wr = tw_cos[k * step];
        wi = inv ? -tw_sin[k * step] : tw_sin[k * step];
        for (int base = 0; base < n; base += len) begin
          p = base + k;
          q = p + half;
          xr = bins_re[q];
          xi = bins_im[q];
          tr = sat32(rnd_shift(wr * xr - wi * xi));
          ti = sat32(rnd_shift(wr * xi + wi * xr));
          ar = bins_re[p];
          ai = bins_im[p];
          bins_re[q] = sat32(ar - tr);
          bins_im[q] = sat32(ai - ti);
          bins_re[p] = sat32(ar + tr);
          bins_im[p] = sat32(ai + ti);
        end
      end
    end
    lim = (peak_last > n - 1) ? n - 1 : peak_last;
    best = '0;
    best_mag = '0;
    for (int i = 0; i <= lim; i++) begin
      xr = bins_re[i];
      xi = bins_im[i];
      mag = longint'(xr * xr) + longint'(xi * xi);
      if (i == 0 || mag > best_mag) begin
        best = i[9:0];
        best_mag = mag;
      end
    end
    return best;
  endfunction

  task automatic predict(fwpb_pkg::in_item_t it);
    fwpb_pkg::out_item_t r;
    r = '0;
    case (it.mode)
      fwpb_pkg::MODE_WRITE: begin
        bins_re[it.point_index] = it.sample_real;
        bins_im[it.point_index] = it.sample_imag;
        n_writes++;
      end
      fwpb_pkg::MODE_FFT: begin
        r.result_kind = fwpb_pkg::KIND_PEAK;
        r.peak_bin = fft_peak();
        expected_q.push_back(r);
        n_ffts++;
      end
      fwpb_pkg::MODE_READ: begin
        r.result_kind = fwpb_pkg::KIND_READ;
        r.bin_real = bins_re[it.point_index];
        r.bin_imag = bins_im[it.point_index];
        expected_q.push_back(r);
        n_reads++;
      end
      default: ;
    endcase
  endtask

  task automatic send(fwpb_pkg::in_item_t it, bit no_gap = 0);
    int g;
    if (!calm && !no_gap && $urandom_range(0, 2) == 0) begin
      g = gap_len();
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict(it);
    @(negedge clk);
  endtask

  task automatic send_write(int idx, int re, int im);
    fwpb_pkg::in_item_t it;
    it.mode = fwpb_pkg::MODE_WRITE;
    it.point_index = idx[9:0];
    it.sample_real = re[15:0];
    it.sample_imag = im[15:0];
    send(it);
  endtask

  task automatic send_op(logic [1:0] m, int idx);
    fwpb_pkg::in_item_t it;
    it.mode = m;
    it.point_index = idx[9:0];
    it.sample_real = 16'($urandom());
    it.sample_imag = 16'($urandom());
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [fwpb_pkg::CfgIdxW-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[fwpb_pkg::CfgDataW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fwpb_pkg::CFG_SIZE_LOG2: size_lg = val[3:0];
      fwpb_pkg::CFG_INVERSE:   inv = val[0];
      fwpb_pkg::CFG_PEAK_LAST: peak_last = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(int sz, int iv, int pk);
    drain();
    write_reg(fwpb_pkg::CFG_SIZE_LOG2, sz);
    write_reg(fwpb_pkg::CFG_INVERSE, iv);
    write_reg(fwpb_pkg::CFG_PEAK_LAST, pk);
  endtask

  // low entries written once so no read or transform sees an unwritten entry
  task automatic test_fill();
    calm = 1;
    for (int i = 0; i < Span; i++)
      send_write(i, $urandom(), $urandom());
    calm = 0;
  endtask

  task automatic test_directed();
    send_write(0, 32767, -32768);
    send_write(1023, -32768, 32767);
    send_op(fwpb_pkg::MODE_READ, 0);
    send_op(fwpb_pkg::MODE_READ, 1023);
    send_op(ModeUnused, 5);
    send_write(5, 0, 0);
    send_op(fwpb_pkg::MODE_READ, 5);
    // largest filled size with saturating extremes
    setup(8, 0, 512);
    send_op(fwpb_pkg::MODE_FFT, 0);
    send_op(fwpb_pkg::MODE_READ, 128);
    setup(1, 0, 1023);
    send_write(0, 32767, 32767);
    send_write(1, 32767, 32767);
    send_op(fwpb_pkg::MODE_FFT, 0);
    send_op(fwpb_pkg::MODE_READ, 1);
    // all zero: tie keeps bin zero
    setup(2, 1, 0);
    for (int i = 0; i < 4; i++) send_write(i, 0, 0);
    send_op(fwpb_pkg::MODE_FFT, 0);
    drain();
    write_reg(fwpb_pkg::CFG_PEAK_LAST, 3);
    send_op(fwpb_pkg::MODE_FFT, 0);
    setup(0, 1, 1023);
    send_op(fwpb_pkg::MODE_FFT, 0);
    setup(7, 0, 1000);
    send_op(fwpb_pkg::MODE_FFT, 0);
    drain();
    write_reg(CfgNoReg, 1023);
    send_op(fwpb_pkg::MODE_READ, 200);
  endtask

  task automatic test_random();
    int sz, r;
    for (int ph = 0; ph < 8; ph++) begin
      sz = (ph == 3) ? 8 : $urandom_range(1, 5);
      setup(sz, $urandom_range(0, 1), $urandom_range(0, 1023));
      calm = (ph == 5);
      for (int i = 0; i < 16; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_write($urandom_range(0, 1023), $urandom(), $urandom());
        else if (r < 88) send_op(fwpb_pkg::MODE_READ, $urandom_range(0, Span - 1));
        else if (r < 92) send_op(ModeUnused, $urandom_range(0, 1023));
        else if (ph != 3 || i % 8 == 0)
          send_op(fwpb_pkg::MODE_FFT, $urandom_range(0, 1023));
      end
      calm = 0;
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 9) < 7) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      fwpb_pkg::out_item_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.bin_real !== e.bin_real) begin
          $error("bin_real exp %0d got %0d", e.bin_real, out_data.bin_real);
          errors++;
        end
        if (out_data.bin_imag !== e.bin_imag) begin
          $error("bin_imag exp %0d got %0d", e.bin_imag, out_data.bin_imag);
          errors++;
        end
        if (out_data.peak_bin !== e.peak_bin) begin
          $error("peak_bin exp %0d got %0d", e.peak_bin, out_data.peak_bin);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout waiting for a beat");
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    calm = 0;
    size_lg = fwpb_pkg::SizeLog2Rst;
    inv = 1'b0;
    peak_last = fwpb_pkg::PeakLastRst;
    foreach (bins_re[i]) begin
      bins_re[i] = 0;
      bins_im[i] = 0;
    end
    build_twiddles();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_fill();
    test_directed();
    test_random();
    drain();
    repeat (50) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("covered %0d writes, %0d reads, %0d transforms; %0d results checked",
             n_writes, n_reads, n_ffts, n_results);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/fwpb_pkg.sv
design/fwpb_ctrl.sv
design/fwpb_datapath.sv
design/fft_with_peak_bin_unit.sv
design/fwpb_checker.sv
sim/testbench.sv
